// ----- rtl/dslg_pkg.sv -----
// ----------------------------------------------------------------------------
// dslg_pkg
// shared types and constants of the decode skip level governor
// ----------------------------------------------------------------------------
`default_nettype none

package dslg_pkg;

  typedef logic [2:0] level_t;

  localparam level_t LEVEL_NONE    = 3'd0;
  localparam level_t LEVEL_DEFAULT = 3'd1;
  localparam level_t LEVEL_NONREF  = 3'd2;
  localparam level_t LEVEL_ALL     = 3'd5;

  localparam logic [2:0] EVAL_PERIOD = 3'd5;

  // capacity offsets of the filter and transform thresholds
  localparam logic signed [8:0] CAP_LO_OFFSET = 9'sd8;
  localparam logic signed [8:0] CAP_HI_OFFSET = 9'sd3;
  // queue trend limits
  localparam logic signed [8:0] RISE_LIMIT = 9'sd3;
  localparam logic signed [8:0] FALL_LIMIT = -9'sd2;

  typedef enum logic [2:0] {
    REG_LOW_THRESHOLD   = 3'd0,
    REG_HIGH_THRESHOLD  = 3'd1,
    REG_QUEUE_CAPACITY  = 3'd2,
    REG_ENABLE_FRAME    = 3'd3,
    REG_ENABLE_FILTER   = 3'd4,
    REG_ENABLE_TRANSFORM = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    level_t frame_level;
    level_t filter_level;
    level_t transform_level;
    logic   evaluated;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/decode_skip_level_governor_core.sv -----
// ----------------------------------------------------------------------------
// decode_skip_level_governor_core
// adjusts frame, loop filter and transform discard levels from queue occupancy
// ----------------------------------------------------------------------------
// usage:
//   item channel (item_valid / item_stall) carries one event per beat: cmd 0 is
//   a decoded frame with the current queue_level, cmd 1 is a seek flush.
//   result channel (result_valid / result_stall) returns one beat per item with
//   the three discard levels after that item and the evaluated flag.
//   every fifth decoded frame runs an evaluation against the thresholds.
//   an accepted item's result is registered in the output register; one item
//   per cycle is sustained while the receiver does not stall, the level state
//   updates in the accept cycle so the next item sees it at once.
//   when the receiver stalls, the result holds in the output register and one
//   more item lands in a skid register; item_stall rises only once that skid
//   register is full.
//   configuration is written through cfg_write / cfg_index / cfg_data; the user
//   writes it only while the block is idle, the block itself does not enforce this.
//   rst (synchronous) restores the register defaults, sets all levels to
//   default, clears period count and snapshot, and empties both result stages.
// ----------------------------------------------------------------------------
`default_nettype none

module decode_skip_level_governor_core
  import dslg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic       cmd,
  input  wire logic [6:0] queue_level,
  output logic            result_valid,
  input  wire logic       result_stall,
  output level_t          frame_level,
  output level_t          filter_level,
  output level_t          transform_level,
  output logic            evaluated
);

  localparam logic [10:0] DEPTH_W = 11'(QUEUE_DEPTH);

  // configuration
  logic [6:0] low_threshold;
  logic [6:0] high_threshold;
  logic [6:0] queue_capacity;
  logic       enable_frame_adjust;
  logic       enable_filter_adjust;
  logic       enable_transform_adjust;

  // governor state
  logic [2:0] period_count;
  logic [6:0] level_snapshot;
  level_t     frame_discard;
  level_t     filter_discard;
  level_t     transform_discard;

  logic [2:0] period_count_next;
  logic [6:0] level_snapshot_next;
  level_t     frame_discard_next;
  level_t     filter_discard_next;
  level_t     transform_discard_next;

  // result stages
  result_t result_reg;
  result_t skid_reg;
  logic    skid_valid;
  result_t result_next;

  logic       accept;
  logic [6:0] q_sat;
  logic [2:0] count_inc;
  logic       eval_now;

  logic signed [8:0] q_s;
  logic signed [8:0] snap_s;
  logic signed [8:0] diff;
  logic signed [8:0] low_s;
  logic signed [8:0] high_s;
  logic signed [8:0] cap_lo;
  logic signed [8:0] cap_hi;

  logic frame_low_trig;
  logic frame_high_trig;
  logic cap_up_trig;
  logic cap_down_trig;

  level_t frame_step;
  level_t filter_step;
  level_t filter_after_frame;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;

  // queue level clamps at the queue depth
  assign q_sat = ({4'b0, queue_level} > DEPTH_W) ? DEPTH_W[6:0] : queue_level;

  assign count_inc = period_count + 3'd1;
  assign eval_now  = (count_inc >= EVAL_PERIOD);

  assign q_s    = $signed({2'b0, q_sat});
  assign snap_s = $signed({2'b0, level_snapshot});
  assign diff   = q_s - snap_s;
  assign low_s  = $signed({2'b0, low_threshold});
  assign high_s = $signed({2'b0, high_threshold});
  assign cap_lo = $signed({2'b0, queue_capacity}) - CAP_LO_OFFSET;
  assign cap_hi = $signed({2'b0, queue_capacity}) - CAP_HI_OFFSET;

  assign frame_low_trig  = (q_s < low_s) && (snap_s > 9'sd0) && (snap_s < low_s)
                           && (diff < RISE_LIMIT);
  assign frame_high_trig = !(q_s < low_s) && (q_s > high_s) && (snap_s > high_s)
                           && (diff > FALL_LIMIT);
  assign cap_up_trig     = (q_s < cap_lo) && (snap_s > 9'sd0) && (snap_s < cap_lo)
                           && (diff < RISE_LIMIT);
  assign cap_down_trig   = !(q_s < cap_lo) && (q_s > cap_hi) && (snap_s > cap_hi)
                           && (diff > FALL_LIMIT);

  // frame adjuster, may force the loop filter to all
  always_comb begin
    frame_step         = frame_discard;
    filter_after_frame = filter_discard;
    if (enable_frame_adjust) begin
      if (frame_low_trig) begin
        if (filter_discard < LEVEL_ALL && enable_filter_adjust) begin
          filter_after_frame = LEVEL_ALL;
        end else if (frame_discard < LEVEL_NONREF) begin
          frame_step = frame_discard + 3'd1;
        end
      end else if (frame_high_trig && frame_discard > LEVEL_DEFAULT) begin
        frame_step = frame_discard - 3'd1;
      end
    end
  end

  // capacity based adjusters see the levels left by the frame adjuster
  always_comb begin
    filter_step = filter_after_frame;
    if (enable_filter_adjust) begin
      if (cap_up_trig && filter_after_frame < LEVEL_ALL) begin
        filter_step = filter_after_frame + 3'd1;
      end else if (cap_down_trig && filter_after_frame > LEVEL_DEFAULT) begin
        filter_step = filter_after_frame - 3'd1;
      end
    end
  end

  always_comb begin
    period_count_next      = period_count;
    level_snapshot_next    = level_snapshot;
    frame_discard_next     = frame_discard;
    filter_discard_next    = filter_discard;
    transform_discard_next = transform_discard;
    result_next.evaluated  = 1'b0;
    if (cmd) begin
      frame_discard_next  = LEVEL_DEFAULT;
      filter_discard_next = LEVEL_DEFAULT;
    end else if (eval_now) begin
      period_count_next     = 3'd0;
      level_snapshot_next   = q_sat;
      frame_discard_next    = frame_step;
      filter_discard_next   = filter_step;
      result_next.evaluated = 1'b1;
      if (enable_transform_adjust) begin
        if (cap_up_trig && transform_discard < LEVEL_ALL) begin
          transform_discard_next = transform_discard + 3'd1;
        end else if (cap_down_trig && transform_discard > LEVEL_DEFAULT) begin
          transform_discard_next = transform_discard - 3'd1;
        end
      end
    end else begin
      period_count_next = count_inc;
    end
    result_next.frame_level     = frame_discard_next;
    result_next.filter_level    = filter_discard_next;
    result_next.transform_level = transform_discard_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold           <= 7'd4;
      high_threshold          <= 7'd20;
      queue_capacity          <= 7'd30;
      enable_frame_adjust     <= 1'b1;
      enable_filter_adjust    <= 1'b1;
      enable_transform_adjust <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOW_THRESHOLD:    low_threshold           <= cfg_data;
        REG_HIGH_THRESHOLD:   high_threshold          <= cfg_data;
        REG_QUEUE_CAPACITY:   queue_capacity          <= cfg_data;
        REG_ENABLE_FRAME:     enable_frame_adjust     <= cfg_data[0];
        REG_ENABLE_FILTER:    enable_filter_adjust    <= cfg_data[0];
        REG_ENABLE_TRANSFORM: enable_transform_adjust <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count      <= 3'd0;
      level_snapshot    <= 7'd0;
      frame_discard     <= LEVEL_DEFAULT;
      filter_discard    <= LEVEL_DEFAULT;
      transform_discard <= LEVEL_DEFAULT;
    end else if (accept) begin
      period_count      <= period_count_next;
      level_snapshot    <= level_snapshot_next;
      frame_discard     <= frame_discard_next;
      filter_discard    <= filter_discard_next;
      transform_discard <= transform_discard_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_reg <= skid_reg;
      end else if (accept) begin
        result_reg <= result_next;
      end
    end else if (accept) begin
      skid_reg <= result_next;
    end
  end

  assign frame_level     = result_reg.frame_level;
  assign filter_level    = result_reg.filter_level;
  assign transform_level = result_reg.transform_level;
  assign evaluated       = result_reg.evaluated;

endmodule

`default_nettype wire

// ----- rtl/dslg_checker.sv -----
// ----------------------------------------------------------------------------
// dslg_checker
// port level checks of the decode skip level governor
// ----------------------------------------------------------------------------
`default_nettype none

module dslg_checker
  import dslg_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   item_valid,
  input wire logic   item_stall,
  input wire logic   cmd,
  input wire logic   result_valid,
  input wire logic   result_stall,
  input wire level_t frame_level,
  input wire level_t filter_level,
  input wire level_t transform_level,
  input wire logic   evaluated
);

  // a stalled result beat stays
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // reset empties both result stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("result stages not empty after reset");

  // the input side stalls only behind a full output register
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item stall with empty output register");

  // levels stay within none .. all
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> frame_level <= LEVEL_ALL && filter_level <= LEVEL_ALL
                     && transform_level <= LEVEL_ALL)
    else $error("discard level out of range");

  // a lone seek beat resets frame and filter levels and never evaluates
  a_seek_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && cmd && !(result_valid && result_stall)
    |=> result_valid && !evaluated && frame_level == LEVEL_DEFAULT
        && filter_level == LEVEL_DEFAULT)
    else $error("seek beat gave wrong result");

endmodule

bind decode_skip_level_governor_core dslg_checker u_dslg_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item_valid),
  .item_stall      (item_stall),
  .cmd             (cmd),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .frame_level     (frame_level),
  .filter_level    (filter_level),
  .transform_level (transform_level),
  .evaluated       (evaluated)
);

`default_nettype wire

// ----- dv/decode_skip_level_governor_core_tb.sv -----
// ----------------------------------------------------------------------------
// decode_skip_level_governor_core_tb
// drives decoded-frame and seek beats through the governor under several
// threshold and enable settings, predicts the three discard levels per beat
// and compares every result beat against the prediction, with random idling
// on both channels
// ----------------------------------------------------------------------------
module decode_skip_level_governor_core_tb;
  import dslg_pkg::*;

  localparam int QDEPTH = 64;

  typedef struct {
    logic       cmd;
    logic [6:0] queue_level;
  } frame_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       cmd = 1'b0;
  logic [6:0] queue_level = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  level_t     frame_level;
  level_t     filter_level;
  level_t     transform_level;
  logic       evaluated;

  decode_skip_level_governor_core #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .queue_level(queue_level),
    .result_valid(result_valid), .result_stall(result_stall),
    .frame_level(frame_level), .filter_level(filter_level),
    .transform_level(transform_level), .evaluated(evaluated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the registers
  int   low_thr = 4;
  int   high_thr = 20;
  int   capacity = 30;
  logic frame_en = 1'b1;
  logic filter_en = 1'b1;
  logic transform_en = 1'b0;

  // shadow copy of the governor state
  logic [2:0] frame_count = '0;
  logic [6:0] snapshot = '0;
  level_t     frame_lv = LEVEL_DEFAULT;
  level_t     filter_lv = LEVEL_DEFAULT;
  level_t     transform_lv = LEVEL_DEFAULT;

  frame_event_t event_q[$];
  result_t      expected_levels[$];

  int   errors = 0;
  int   n_beats = 0;
  int   n_seeks = 0;
  int   n_evals = 0;
  int   n_settings = 1;
  bit   quiet = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;

  // filter and transform follow the capacity based thresholds
  function automatic level_t step_by_capacity(level_t lv, int q, int snap);
    int lo;
    int hi;
    int diff;
    lo = capacity - int'(CAP_LO_OFFSET);
    hi = capacity - int'(CAP_HI_OFFSET);
    diff = q - snap;
    if (q < lo) begin
      if (snap > 0 && snap < lo && diff < int'(RISE_LIMIT) && lv < LEVEL_ALL) lv = lv + 3'd1;
    end else if (q > hi) begin
      if (snap > hi && diff > int'(FALL_LIMIT) && lv > LEVEL_DEFAULT) lv = lv - 3'd1;
    end
    return lv;
  endfunction

  function automatic result_t next_levels(frame_event_t ev);
    int      q;
    int      snap;
    int      diff;
    result_t r;
    r.evaluated = 1'b0;
    q = (ev.queue_level > QDEPTH) ? QDEPTH : int'(ev.queue_level);
    if (ev.cmd) begin
      frame_lv = LEVEL_DEFAULT;
      filter_lv = LEVEL_DEFAULT;
    end else begin
      frame_count = frame_count + 3'd1;
      if (frame_count >= EVAL_PERIOD) begin
        snap = int'(snapshot);
        diff = q - snap;
        frame_count = '0;
        r.evaluated = 1'b1;
        if (frame_en) begin
          if (q < low_thr) begin
            if (snap > 0 && snap < low_thr && diff < int'(RISE_LIMIT)) begin
              // queue starving: drop the loop filter first, then frames
              if (filter_lv < LEVEL_ALL && filter_en) filter_lv = LEVEL_ALL;
              else if (frame_lv < LEVEL_NONREF) frame_lv = frame_lv + 3'd1;
            end
          end else if (q > high_thr) begin
            if (snap > high_thr && diff > int'(FALL_LIMIT) && frame_lv > LEVEL_DEFAULT)
              frame_lv = frame_lv - 3'd1;
          end
        end
        if (filter_en) filter_lv = step_by_capacity(filter_lv, q, snap);
        if (transform_en) transform_lv = step_by_capacity(transform_lv, q, snap);
        snapshot = q[6:0];
      end
    end
    r.frame_level = frame_lv;
    r.filter_level = filter_lv;
    r.transform_level = transform_lv;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    logic         nxt_valid;
    frame_event_t ev;
    if (!rst) begin
      nxt_valid = item_valid;
      if (item_valid && !item_stall) begin
        ev.cmd = cmd;
        ev.queue_level = queue_level;
        expected_levels.push_back(next_levels(ev));
        n_beats++;
        if (cmd) n_seeks++;
        nxt_valid = 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (event_q.size() > 0) begin
          ev = event_q.pop_front();
          cmd <= ev.cmd;
          queue_level <= ev.queue_level;
          nxt_valid = 1'b1;
        end
      end
      item_valid <= nxt_valid;
    end
  end

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    result_t want;
    logic    nxt_stall;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_levels.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none actual %0d/%0d/%0d/%0d",
                   $time, frame_level, filter_level, transform_level, evaluated);
        end else begin
          want = expected_levels.pop_front();
          if ({frame_level, filter_level, transform_level, evaluated} !== want) begin
            if ($isunknown({frame_level, filter_level, transform_level, evaluated})) begin
              errors++;
              $display("%0t: unknown bits in result, expected %h actual %h", $time, want,
                       {frame_level, filter_level, transform_level, evaluated});
            end else begin
              report_field("frame_level", want.frame_level, frame_level);
              report_field("filter_level", want.filter_level, filter_level);
              report_field("transform_level", want.transform_level, transform_level);
              report_field("evaluated", want.evaluated, evaluated);
            end
          end
          if (evaluated === 1'b1) n_evals++;
        end
      end
      nxt_stall = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        nxt_stall = 1'b1;
      end
      result_stall <= nxt_stall;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [6:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_LOW_THRESHOLD:    low_thr = int'(data);
      REG_HIGH_THRESHOLD:   high_thr = int'(data);
      REG_QUEUE_CAPACITY:   capacity = int'(data);
      REG_ENABLE_FRAME:     frame_en = data[0];
      REG_ENABLE_FILTER:    filter_en = data[0];
      REG_ENABLE_TRANSFORM: transform_en = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_regs(logic [6:0] lo, logic [6:0] hi, logic [6:0] cap,
                          logic [6:0] fr, logic [6:0] fl, logic [6:0] tr);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_QUEUE_CAPACITY, cap);
    write_reg(REG_ENABLE_FRAME, fr);
    write_reg(REG_ENABLE_FILTER, fl);
    write_reg(REG_ENABLE_TRANSFORM, tr);
    n_settings++;
  endtask

  task automatic put(logic c, logic [6:0] ql);
    frame_event_t ev;
    ev.cmd = c;
    ev.queue_level = ql;
    event_q.push_back(ev);
  endtask

  // every beat sent and every result back
  task automatic drain();
    do @(negedge clk);
    while (event_q.size() != 0 || item_valid || expected_levels.size() != 0);
  endtask

  // queue occupancy wanders slowly around one of the thresholds or a random level, so the
  // trend conditions get hit; seeks and wild levels are sprinkled in
  task automatic wander(int count);
    int center;
    int lvl;
    int run;
    while (count > 0) begin
      case ($urandom_range(0, 4))
        0: center = low_thr;
        1: center = high_thr;
        2: center = capacity - 8;
        3: center = capacity - 3;
        default: center = $urandom_range(0, QDEPTH);
      endcase
      lvl = center + $urandom_range(0, 8) - 4;
      run = $urandom_range(15, 40);
      while (run > 0 && count > 0) begin
        lvl = lvl + $urandom_range(0, 4) - 2;
        if (lvl < 0) lvl = 0;
        if (lvl > QDEPTH) lvl = QDEPTH;
        if ($urandom_range(0, 29) == 0) put(1'b1, 7'($urandom_range(0, 127)));
        else if ($urandom_range(0, 24) == 0) put(1'b0, 7'($urandom_range(0, 127)));
        else put(1'b0, 7'(lvl));
        run--;
        count--;
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: starvation forces the filter, then frames escalate, seek
    // clears, then levels past the queue depth
    put(1'b1, 7'd127);
    repeat (5) put(1'b0, 7'd2);
    repeat (5) put(1'b0, 7'd3);
    repeat (5) put(1'b0, 7'd1);
    put(1'b1, 7'd0);
    put(1'b0, 7'd127);
    put(1'b0, 7'd65);
    put(1'b0, 7'd100);
    put(1'b0, 7'd0);
    put(1'b0, 7'd64);
    drain();

    set_regs(7'd10, 7'd24, 7'd30, 7'h01, 7'h01, 7'h01);
    wander(130);
    // all thresholds at zero, filter adjust off
    set_regs(7'd0, 7'd0, 7'd0, 7'h7F, 7'h7E, 7'h7F);
    wander(120);
    set_regs(7'd64, 7'd64, 7'd64, 7'h01, 7'h01, 7'h01);
    wander(120);
    // inverted frame thresholds and a capacity below both offsets
    set_regs(7'd12, 7'd5, 7'd2, 7'h40, 7'h41, 7'h03);
    wander(120);
    for (int p = 0; p < 9; p++) begin
      set_regs(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
               7'($urandom_range(0, 64)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      if (p == 8) quiet = 1'b1;
      wander(130);
    end

    repeat (10) @(negedge clk);
    errors += expected_levels.size();
    $display("covered %0d beats (%0d seeks, %0d evaluations) over %0d register settings",
             n_beats, n_seeks, n_evals, n_settings);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- decode_skip_level_governor_core.f -----
rtl/dslg_pkg.sv
rtl/decode_skip_level_governor_core.sv
rtl/dslg_checker.sv
dv/decode_skip_level_governor_core_tb.sv
